/* rtl/core/lfws_pkg.sv */
// ----------------------------------------------------------------------------
// lfws_pkg
// shared types, codes and constants of the wheel speed and line follow unit
// ----------------------------------------------------------------------------
package lfws_pkg;

  // sensor and arithmetic widths
  localparam int unsigned ADC_BITS   = 10;
  localparam int unsigned ERR_W      = ADC_BITS + 1;
  localparam int unsigned DERR_W     = ERR_W + 1;
  localparam int unsigned WERR_W     = 14;
  localparam int unsigned MUL_W      = 17;
  localparam int unsigned ACC_W      = 50;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // compare = floor(period * duty / 100) = floor(floor(x / 4) / 25)
  localparam int unsigned CMP_PROD_W  = 23;
  localparam int unsigned RECIP_W     = 22;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] RECIP_25 = 22'd2684355;

  localparam logic signed [7:0] LINE_MIN = 8'sd5;
  localparam logic signed [7:0] LINE_MAX = 8'sd60;
  localparam logic [6:0]        DUTY_MAX = 7'd100;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_P   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_I   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_P    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_D    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_I    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_RPM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PER   = 3'd6;

  typedef enum logic [1:0] {
    FUNC_SET   = 2'd0,
    FUNC_LINE  = 2'd1,
    FUNC_SPEED = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SET,
    ST_L_PREP,
    ST_L_MUL_P,
    ST_L_MUL_D,
    ST_L_MUL_IL,
    ST_L_MUL_IH,
    ST_L_SCALE,
    ST_L_STEER,
    ST_L_BACK_L,
    ST_L_BACK_R,
    ST_W_PREP,
    ST_W_MUL_P,
    ST_W_MUL_I,
    ST_W_DUTY,
    ST_W_CMP1,
    ST_W_CMP2,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SET,
    OP_L_PREP,
    OP_L_MUL_P,
    OP_L_MUL_D,
    OP_L_MUL_IL,
    OP_L_MUL_IH,
    OP_L_SCALE,
    OP_L_STEER,
    OP_L_BACK_L,
    OP_L_BACK_R,
    OP_W_PREP,
    OP_W_MUL_P,
    OP_W_MUL_I,
    OP_W_DUTY,
    OP_W_CMP1,
    OP_W_CMP2,
    OP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   wheel;   // 0 left, 1 right
  } dp_cmd_t;

  typedef struct packed {
    logic follow;
  } dp_status_t;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [7:0]       command_left;
    logic signed [7:0]       command_right;
    logic                    follow_enable;
    logic [ADC_BITS-1:0]     sensor_left;
    logic [ADC_BITS-1:0]     sensor_right;
    logic signed [11:0]      measured_left;
    logic signed [11:0]      measured_right;
  } item_t;

  typedef struct packed {
    logic signed [7:0] left_target;
    logic signed [7:0] right_target;
    logic [6:0]        left_duty;
    logic [6:0]        right_duty;
    dir_e              left_dir;
    dir_e              right_dir;
    logic [15:0]       left_fwd_compare;
    logic [15:0]       left_rev_compare;
    logic [15:0]       right_fwd_compare;
    logic [15:0]       right_rev_compare;
  } result_t;

endpackage

/* rtl/core/lfws_item_if.sv */
// ----------------------------------------------------------------------------
// lfws_item_if
// request channel into the unit: valid, ready and the item fields
// ----------------------------------------------------------------------------
interface lfws_item_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic signed [7:0]             command_left;
  logic signed [7:0]             command_right;
  logic                          follow_enable;
  logic [lfws_pkg::ADC_BITS-1:0] sensor_left;
  logic [lfws_pkg::ADC_BITS-1:0] sensor_right;
  logic signed [11:0]            measured_left;
  logic signed [11:0]            measured_right;

  modport source (
    output valid, func, command_left, command_right, follow_enable,
           sensor_left, sensor_right, measured_left, measured_right,
    input  ready
  );
  modport sink (
    input  valid, func, command_left, command_right, follow_enable,
           sensor_left, sensor_right, measured_left, measured_right,
    output ready
  );
endinterface

/* rtl/core/lfws_result_if.sv */
// ----------------------------------------------------------------------------
// lfws_result_if
// result channel out of the unit: valid, ready and the result fields
// ----------------------------------------------------------------------------
interface lfws_result_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] left_target;
  logic signed [7:0] right_target;
  logic [6:0]        left_duty;
  logic [6:0]        right_duty;
  logic [1:0]        left_dir;
  logic [1:0]        right_dir;
  logic [15:0]       left_fwd_compare;
  logic [15:0]       left_rev_compare;
  logic [15:0]       right_fwd_compare;
  logic [15:0]       right_rev_compare;

  modport source (
    output valid, left_target, right_target, left_duty, right_duty, left_dir,
           right_dir, left_fwd_compare, left_rev_compare, right_fwd_compare,
           right_rev_compare,
    input  ready
  );
  modport sink (
    input  valid, left_target, right_target, left_duty, right_duty, left_dir,
           right_dir, left_fwd_compare, left_rev_compare, right_fwd_compare,
           right_rev_compare,
    output ready
  );
endinterface

/* rtl/core/line_follow_wheel_speed_pid_unit.sv */
// ----------------------------------------------------------------------------
// line_follow_wheel_speed_pid_unit
// two-wheel speed PI with anti-windup and a line-following PID steering stage
// ----------------------------------------------------------------------------
// One request in, one result out, one request at a time. A set-targets
// request runs the set step, a line sample the line PID steps (none with
// follow mode off), a speed sample the wheel steps of both wheels; unused
// function codes go straight to the result register. The single shared 17x17
// signed multiplier sets the sequence: the line PID needs four passes through
// it (proportional, derivative, and the 32-bit integral split into two 16-bit
// halves) and each wheel needs three (proportional, integral, period times
// duty), with the wheels handled one after the other. A request may be
// accepted while the previous result still waits in the result register; the
// sequencer then holds the new one at its end until the register frees.
// Configuration writes are taken at any edge but are meant for idle time.
module line_follow_wheel_speed_pid_unit #(
  parameter int unsigned GAIN_FRAC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  lfws_item_if.sink                           item_i,
  lfws_result_if.source                       result_o,
  input  logic                                cfg_we_i,
  input  logic [lfws_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lfws_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import lfws_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  item_t      item;
  result_t    result;

  // pack the incoming request fields
  assign item.func           = item_i.func;
  assign item.command_left   = item_i.command_left;
  assign item.command_right  = item_i.command_right;
  assign item.follow_enable  = item_i.follow_enable;
  assign item.sensor_left    = item_i.sensor_left;
  assign item.sensor_right   = item_i.sensor_right;
  assign item.measured_left  = item_i.measured_left;
  assign item.measured_right = item_i.measured_right;

  // sequencer: decodes the function code at acceptance, walks the
  // multiply-accumulate steps, then loads the result register
  lfws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_func_i   (item_i.func),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: gains, targets, integrators, held duty/compare registers
  lfws_dp #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .item_i     (item),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (result)
  );

  // unpack the result register onto the channel
  assign result_o.left_target       = result.left_target;
  assign result_o.right_target      = result.right_target;
  assign result_o.left_duty         = result.left_duty;
  assign result_o.right_duty        = result.right_duty;
  assign result_o.left_dir          = result.left_dir;
  assign result_o.right_dir         = result.right_dir;
  assign result_o.left_fwd_compare  = result.left_fwd_compare;
  assign result_o.left_rev_compare  = result.left_rev_compare;
  assign result_o.right_fwd_compare = result.right_fwd_compare;
  assign result_o.right_rev_compare = result.right_rev_compare;

endmodule

/* rtl/core/lfws_ctrl.sv */
// ----------------------------------------------------------------------------
// lfws_ctrl
// sequencer: steps the datapath through one request and owns the handshakes
// ----------------------------------------------------------------------------
module lfws_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_func_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  lfws_pkg::dp_status_t status_i,
  output lfws_pkg::dp_cmd_t    cmd_o
);
  import lfws_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        wheel_q, wheel_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wheel_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wheel_q     <= wheel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    wheel_d = wheel_q;
    case (state_q)
      ST_IDLE: begin
        wheel_d = 1'b0;
        if (in_valid_i) begin
          case (func_e'(in_func_i))
            FUNC_SET:   state_d = ST_SET;
            FUNC_LINE:  state_d = status_i.follow ? ST_L_PREP : ST_DONE;
            FUNC_SPEED: state_d = ST_W_PREP;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_SET:      state_d = ST_DONE;
      ST_L_PREP:   state_d = ST_L_MUL_P;
      ST_L_MUL_P:  state_d = ST_L_MUL_D;
      ST_L_MUL_D:  state_d = ST_L_MUL_IL;
      ST_L_MUL_IL: state_d = ST_L_MUL_IH;
      ST_L_MUL_IH: state_d = ST_L_SCALE;
      ST_L_SCALE:  state_d = ST_L_STEER;
      ST_L_STEER:  state_d = ST_L_BACK_L;
      ST_L_BACK_L: state_d = ST_L_BACK_R;
      ST_L_BACK_R: state_d = ST_DONE;
      ST_W_PREP:   state_d = ST_W_MUL_P;
      ST_W_MUL_P:  state_d = ST_W_MUL_I;
      ST_W_MUL_I:  state_d = ST_W_DUTY;
      ST_W_DUTY:   state_d = ST_W_CMP1;
      ST_W_CMP1:   state_d = ST_W_CMP2;
      ST_W_CMP2: begin
        if (!wheel_q) begin
          wheel_d = 1'b1;
          state_d = ST_W_PREP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.wheel = wheel_q;
    cmd_o.op    = OP_NONE;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_CAPTURE;
      end
      ST_SET:      cmd_o.op = OP_SET;
      ST_L_PREP:   cmd_o.op = OP_L_PREP;
      ST_L_MUL_P:  cmd_o.op = OP_L_MUL_P;
      ST_L_MUL_D:  cmd_o.op = OP_L_MUL_D;
      ST_L_MUL_IL: cmd_o.op = OP_L_MUL_IL;
      ST_L_MUL_IH: cmd_o.op = OP_L_MUL_IH;
      ST_L_SCALE:  cmd_o.op = OP_L_SCALE;
      ST_L_STEER:  cmd_o.op = OP_L_STEER;
      ST_L_BACK_L: cmd_o.op = OP_L_BACK_L;
      ST_L_BACK_R: cmd_o.op = OP_L_BACK_R;
      ST_W_PREP:   cmd_o.op = OP_W_PREP;
      ST_W_MUL_P:  cmd_o.op = OP_W_MUL_P;
      ST_W_MUL_I:  cmd_o.op = OP_W_MUL_I;
      ST_W_DUTY:   cmd_o.op = OP_W_DUTY;
      ST_W_CMP1:   cmd_o.op = OP_W_CMP1;
      ST_W_CMP2:   cmd_o.op = OP_W_CMP2;
      ST_DONE: begin
        if (out_free) cmd_o.op = OP_LOAD_OUT;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  // result register valid
  always_comb begin
    if (state_q == ST_DONE && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/lfws_dp.sv */
// ----------------------------------------------------------------------------
// lfws_dp
// datapath: configuration, controller state, shared multiply-accumulate,
// scaling, clamps and the result register
// ----------------------------------------------------------------------------
module lfws_dp #(
  parameter int unsigned GAIN_FRAC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lfws_pkg::dp_cmd_t                   cmd_i,
  output lfws_pkg::dp_status_t                status_o,
  input  lfws_pkg::item_t                     item_i,
  input  logic                                cfg_we_i,
  input  logic [lfws_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lfws_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output lfws_pkg::result_t                   result_o
);
  import lfws_pkg::*;

  localparam int unsigned STEER_W = ACC_W + 1;
  localparam logic signed [ACC_W-1:0] RoundBias =
    {{(ACC_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else                r = $signed(v[31:0]);
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v[16] != v[15]) r = v[16] ? 16'sh8000 : 16'sh7FFF;
    else                r = $signed(v[15:0]);
    return r;
  endfunction

  // configuration
  logic [15:0] speed_p_q, speed_i_q, line_p_q, line_d_q, line_i_q, period_q;
  logic [6:0]  base_q;

  // block state
  logic signed [7:0]        tgt_l_q, tgt_r_q;
  logic                     follow_q;
  logic signed [15:0]       integ_l_q, integ_r_q;
  logic signed [31:0]       line_int_q;
  logic signed [ERR_W-1:0]  prev_err_q;
  logic [6:0]               duty_l_q, duty_r_q;
  dir_e                     dir_l_q, dir_r_q;
  logic [15:0]              cmp_lf_q, cmp_lr_q, cmp_rf_q, cmp_rr_q;

  // working registers
  item_t                    item_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [DERR_W-1:0] derr_q;
  logic signed [31:0]       total_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  chg_q;
  logic                     clamp_l_q, clamp_r_q;
  logic signed [WERR_W-1:0] werr_q;
  logic signed [15:0]       newint_q;
  logic [6:0]               duty_q;
  logic [CMP_PROD_W-1:0]    prod_q;
  result_t                  res_q;

  // combinational
  logic signed [ERR_W-1:0]     err_c;
  logic signed [DERR_W-1:0]    derr_c;
  logic signed [31:0]          total_c, back_c;
  logic signed [MUL_W-1:0]     mul_a, mul_b;
  logic signed [2*MUL_W-1:0]   mul_p;
  logic signed [ACC_W-1:0]     mul_ext, acc_add;
  logic signed [ACC_W-1:0]     acc_rnd, scaled;
  logic signed [STEER_W-1:0]   base_x, nl, nr;
  logic signed [7:0]           nl_sat, nr_sat;
  logic                        nl_clamp, nr_clamp;
  logic signed [7:0]           tgt_sel;
  logic signed [8:0]           tgt_x, mag;
  logic signed [11:0]          meas_sel;
  logic signed [15:0]          integ_sel;
  logic signed [WERR_W-1:0]    werr_c;
  logic signed [15:0]          newint_c;
  logic signed [ACC_W-1:0]     duty_cap;
  logic [RECIP_W+CMP_PROD_W-3:0] recip_p;
  logic [15:0]                 cmp_c;

  assign status_o.follow = follow_q;

  // line error terms
  assign err_c   = $signed({1'b0, item_q.sensor_left}) - $signed({1'b0, item_q.sensor_right});
  assign derr_c  = DERR_W'(err_q) - DERR_W'(prev_err_q);
  assign total_c = sat32(33'(line_int_q) + 33'(err_c));
  assign back_c  = sat32(33'(total_q) - 33'(err_q));

  // shared multiplier, gains enter as positive 17-bit values
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_L_MUL_P: begin
        mul_a = $signed({1'b0, line_p_q});
        mul_b = MUL_W'(err_q);
      end
      OP_L_MUL_D: begin
        mul_a = $signed({1'b0, line_d_q});
        mul_b = MUL_W'(derr_q);
      end
      OP_L_MUL_IL: begin
        mul_a = $signed({1'b0, line_i_q});
        mul_b = $signed({1'b0, total_q[15:0]});
      end
      OP_L_MUL_IH: begin
        mul_a = $signed({1'b0, line_i_q});
        mul_b = MUL_W'($signed(total_q[31:16]));
      end
      OP_W_MUL_P: begin
        mul_a = $signed({1'b0, speed_p_q});
        mul_b = MUL_W'(werr_q);
      end
      OP_W_MUL_I: begin
        mul_a = $signed({1'b0, speed_i_q});
        mul_b = MUL_W'(newint_q);
      end
      OP_W_CMP1: begin
        mul_a = $signed({1'b0, period_q});
        mul_b = $signed({{(MUL_W-7){1'b0}}, duty_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_ext = ACC_W'(mul_p);
  // upper half of the line integral weighs 2^16
  assign acc_add = (cmd_i.op == OP_L_MUL_IH) ? (mul_ext <<< 16) : mul_ext;

  // divide by 2^frac, truncating toward zero
  assign acc_rnd = acc_q + (acc_q[ACC_W-1] ? RoundBias : '0);
  assign scaled  = acc_rnd >>> GAIN_FRAC_BITS;

  // steering around the base speed
  assign base_x   = $signed({{(STEER_W-7){1'b0}}, base_q});
  assign nl       = base_x - STEER_W'(chg_q);
  assign nr       = base_x + STEER_W'(chg_q);
  assign nl_clamp = (nl > LINE_MAX) || (nl < LINE_MIN);
  assign nr_clamp = (nr > LINE_MAX) || (nr < LINE_MIN);
  assign nl_sat   = (nl > LINE_MAX) ? LINE_MAX : ((nl < LINE_MIN) ? LINE_MIN : $signed(nl[7:0]));
  assign nr_sat   = (nr > LINE_MAX) ? LINE_MAX : ((nr < LINE_MIN) ? LINE_MIN : $signed(nr[7:0]));

  // wheel selection
  assign tgt_sel   = cmd_i.wheel ? tgt_r_q : tgt_l_q;
  assign meas_sel  = cmd_i.wheel ? item_q.measured_right : item_q.measured_left;
  assign integ_sel = cmd_i.wheel ? integ_r_q : integ_l_q;
  assign tgt_x     = 9'(tgt_sel);
  assign mag       = tgt_x[8] ? -tgt_x : tgt_x;
  assign werr_c    = WERR_W'(mag) - WERR_W'(meas_sel);
  assign newint_c  = sat16(17'(integ_sel) + 17'(werr_c));
  assign duty_cap  = ACC_W'(DUTY_MAX);

  // floor(x / 100): drop two bits, then reciprocal multiply for 25
  assign recip_p = {{RECIP_W{1'b0}}, prod_q[CMP_PROD_W-1:2]}
                 * {{(CMP_PROD_W-2){1'b0}}, RECIP_25};
  assign cmp_c   = recip_p[RECIP_SHIFT +: 16];

  // configuration and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_p_q  <= 16'd410;
      speed_i_q  <= 16'd123;
      line_p_q   <= 16'd41;
      line_d_q   <= 16'd819;
      line_i_q   <= 16'd0;
      base_q     <= 7'd35;
      period_q   <= 16'd249;
      tgt_l_q    <= '0;
      tgt_r_q    <= '0;
      follow_q   <= 1'b0;
      integ_l_q  <= '0;
      integ_r_q  <= '0;
      line_int_q <= '0;
      prev_err_q <= '0;
      duty_l_q   <= '0;
      duty_r_q   <= '0;
      dir_l_q    <= DIR_STOP;
      dir_r_q    <= DIR_STOP;
      cmp_lf_q   <= '0;
      cmp_lr_q   <= '0;
      cmp_rf_q   <= '0;
      cmp_rr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SPEED_P:  speed_p_q <= cfg_data_i;
          CFG_SPEED_I:  speed_i_q <= cfg_data_i;
          CFG_LINE_P:   line_p_q  <= cfg_data_i;
          CFG_LINE_D:   line_d_q  <= cfg_data_i;
          CFG_LINE_I:   line_i_q  <= cfg_data_i;
          CFG_BASE_RPM: base_q    <= cfg_data_i[6:0];
          CFG_PWM_PER:  period_q  <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_SET: begin
          tgt_l_q  <= item_q.command_left;
          tgt_r_q  <= item_q.command_right;
          follow_q <= item_q.follow_enable;
        end
        OP_L_STEER: begin
          tgt_l_q    <= nl_sat;
          tgt_r_q    <= nr_sat;
          prev_err_q <= err_q;
        end
        OP_L_BACK_R: begin
          line_int_q <= clamp_r_q ? back_c : total_q;
        end
        OP_W_DUTY: begin
          if (scaled > duty_cap) begin
            if (cmd_i.wheel) duty_r_q <= DUTY_MAX;
            else             duty_l_q <= DUTY_MAX;
          end else if (scaled[ACC_W-1]) begin
            if (cmd_i.wheel) duty_r_q <= '0;
            else             duty_l_q <= '0;
          end else begin
            if (cmd_i.wheel) begin
              duty_r_q  <= scaled[6:0];
              integ_r_q <= newint_q;
            end else begin
              duty_l_q  <= scaled[6:0];
              integ_l_q <= newint_q;
            end
          end
          if (cmd_i.wheel) dir_r_q <= tgt_sel[7] ? DIR_REV : ((tgt_sel == 0) ? DIR_STOP : DIR_FWD);
          else             dir_l_q <= tgt_sel[7] ? DIR_REV : ((tgt_sel == 0) ? DIR_STOP : DIR_FWD);
        end
        OP_W_CMP2: begin
          if (cmd_i.wheel) begin
            cmp_rf_q <= (!tgt_sel[7] && tgt_sel != 0) ? cmp_c : '0;
            cmp_rr_q <= tgt_sel[7] ? cmp_c : '0;
          end else begin
            cmp_lf_q <= (!tgt_sel[7] && tgt_sel != 0) ? cmp_c : '0;
            cmp_lr_q <= tgt_sel[7] ? cmp_c : '0;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: item_q <= item_i;
      OP_L_PREP: begin
        err_q   <= err_c;
        total_q <= total_c;
        acc_q   <= '0;
      end
      OP_L_MUL_P: begin
        derr_q <= derr_c;
        acc_q  <= acc_q + acc_add;
      end
      OP_L_MUL_D, OP_L_MUL_IL, OP_L_MUL_IH, OP_W_MUL_P, OP_W_MUL_I: begin
        acc_q <= acc_q + acc_add;
      end
      OP_L_SCALE: chg_q <= scaled;
      OP_L_STEER: begin
        clamp_l_q <= nl_clamp;
        clamp_r_q <= nr_clamp;
      end
      OP_L_BACK_L: begin
        if (clamp_l_q) total_q <= back_c;
      end
      OP_W_PREP: begin
        werr_q   <= werr_c;
        newint_q <= newint_c;
        acc_q    <= '0;
      end
      OP_W_DUTY: begin
        if (scaled > duty_cap)      duty_q <= DUTY_MAX;
        else if (scaled[ACC_W-1])   duty_q <= '0;
        else                        duty_q <= scaled[6:0];
      end
      OP_W_CMP1: prod_q <= mul_p[CMP_PROD_W-1:0];
      OP_LOAD_OUT: begin
        res_q.left_target       <= tgt_l_q;
        res_q.right_target      <= tgt_r_q;
        res_q.left_duty         <= duty_l_q;
        res_q.right_duty        <= duty_r_q;
        res_q.left_dir          <= dir_l_q;
        res_q.right_dir         <= dir_r_q;
        res_q.left_fwd_compare  <= cmp_lf_q;
        res_q.left_rev_compare  <= cmp_lr_q;
        res_q.right_fwd_compare <= cmp_rf_q;
        res_q.right_rev_compare <= cmp_rr_q;
      end
      default: ;
    endcase
  end

  assign result_o = res_q;

endmodule

/* rtl/core/lfws_checker.sv */
// ----------------------------------------------------------------------------
// lfws_checker
// port-level checks on the wheel speed and line follow unit
// ----------------------------------------------------------------------------
module lfws_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [6:0]  left_duty_i,
  input logic [6:0]  right_duty_i,
  input logic [1:0]  left_dir_i,
  input logic [1:0]  right_dir_i,
  input logic [15:0] left_fwd_i,
  input logic [15:0] left_rev_i,
  input logic [15:0] right_fwd_i,
  input logic [15:0] right_rev_i
);
  import lfws_pkg::*;

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(left_fwd_i)
      && $stable(right_fwd_i) && $stable(left_duty_i) && $stable(right_duty_i))
    else $error("result changed while stalled");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  // only the side matching the direction drives a compare
  a_left_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (left_dir_i == DIR_FWD || left_fwd_i == 16'd0)
      && (left_dir_i == DIR_REV || left_rev_i == 16'd0))
    else $error("left compare on wrong side");

  a_right_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (right_dir_i == DIR_FWD || right_fwd_i == 16'd0)
      && (right_dir_i == DIR_REV || right_rev_i == 16'd0))
    else $error("right compare on wrong side");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> left_duty_i <= DUTY_MAX && right_duty_i <= DUTY_MAX)
    else $error("duty above full scale");

endmodule

bind line_follow_wheel_speed_pid_unit lfws_checker u_lfws_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .left_duty_i  (result_o.left_duty),
  .right_duty_i (result_o.right_duty),
  .left_dir_i   (result_o.left_dir),
  .right_dir_i  (result_o.right_dir),
  .left_fwd_i   (result_o.left_fwd_compare),
  .left_rev_i   (result_o.left_rev_compare),
  .right_fwd_i  (result_o.right_fwd_compare),
  .right_rev_i  (result_o.right_rev_compare)
);
